// File: src/efla_pkg.sv
package efla_pkg;

   localparam int HEAP_BYTES_DEF  = 1048576;
   localparam int CHUNK_BYTES_DEF = 65536;
   localparam int MIN_BLOCK       = 32;
   localparam int WORD_BYTES      = 8;
   localparam int TAG_BYTES       = 16;
   localparam int REQ_W           = 21;
   localparam int ADDR_W          = 20;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              ok;
   } res_type;

endpackage

// File: src/efla_ram.sv
module efla_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/efla_ctrl.sv
module efla_ctrl #(
   parameter int HEAP_BYTES  = efla_pkg::HEAP_BYTES_DEF,
   parameter int CHUNK_BYTES = efla_pkg::CHUNK_BYTES_DEF,
   localparam int DW = $clog2(HEAP_BYTES) + 1,
   localparam int IW = $clog2(HEAP_BYTES / 8)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [efla_pkg::REQ_W-1:0] req_size,
   input  logic [efla_pkg::ADDR_W-1:0] req_free_addr,
   output logic                       mem_we,
   output logic [IW-1:0]              mem_idx,
   output logic [DW-1:0]              mem_wdata,
   input  logic [DW-1:0]              mem_rdata,
   input  logic                       out_busy,
   output efla_pkg::res_type          res
);
   import efla_pkg::*;

   localparam int SW = ((DW > 22) ? DW : 22) + 1;

   localparam logic [SW-1:0] C_WORD  = SW'(WORD_BYTES);
   localparam logic [SW-1:0] C_TAG   = SW'(TAG_BYTES);
   localparam logic [SW-1:0] C_MIN   = SW'(MIN_BLOCK);
   localparam logic [SW-1:0] C_CHUNK = SW'(CHUNK_BYTES);
   localparam logic [SW-1:0] C_HEAP  = SW'(HEAP_BYTES);
   localparam logic [SW-1:0] C_ONE   = SW'(1);
   localparam logic [SW-1:0] C_ALIGN = SW'(WORD_BYTES + TAG_BYTES - 1);
   localparam logic [SW-1:0] SZ_MASK = ~SW'(7);

   localparam logic [2:0] INIT_LAST = 3'd5;

   localparam logic [4:0] ST_INIT   = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_FF_CHK = 5'd2;
   localparam logic [4:0] ST_FF_NXT = 5'd3;
   localparam logic [4:0] ST_GROW   = 5'd4;
   localparam logic [4:0] ST_GR_EPI = 5'd5;
   localparam logic [4:0] ST_FR_CHK = 5'd6;
   localparam logic [4:0] ST_MG_RB  = 5'd7;
   localparam logic [4:0] ST_MG_RA  = 5'd8;
   localparam logic [4:0] ST_MG_AF  = 5'd9;
   localparam logic [4:0] ST_MG_BF  = 5'd10;
   localparam logic [4:0] ST_MG_TG  = 5'd11;
   localparam logic [4:0] ST_MG_PS  = 5'd12;
   localparam logic [4:0] ST_PL0    = 5'd13;
   localparam logic [4:0] ST_PL1    = 5'd14;
   localparam logic [4:0] ST_PL2    = 5'd15;
   localparam logic [4:0] ST_PL3    = 5'd16;
   localparam logic [4:0] ST_LR0    = 5'd17;
   localparam logic [4:0] ST_LR1    = 5'd18;
   localparam logic [4:0] ST_LR2    = 5'd19;
   localparam logic [4:0] ST_LR3    = 5'd20;
   localparam logic [4:0] ST_TG0    = 5'd21;
   localparam logic [4:0] ST_TG1    = 5'd22;
   localparam logic [4:0] ST_PU0    = 5'd23;
   localparam logic [4:0] ST_PU1    = 5'd24;
   localparam logic [4:0] ST_PU2    = 5'd25;
   localparam logic [4:0] ST_RESP   = 5'd26;

   logic [4:0]        state_ff, state_in, ret_ff, ret_in;
   logic [2:0]        init_ff, init_in;
   logic              func_ff, func_in;
   logic [SW-1:0]     b_ff, b_in, target_ff, target_in, blk_ff, blk_in;
   logic [SW-1:0]     size_ff, size_in, asize_ff, asize_in, before_ff, before_in;
   logic [SW-1:0]     x_ff, x_in, n_ff, n_in, p_ff, p_in;
   logic [SW-1:0]     t_addr_ff, t_addr_in, t_word_ff, t_word_in;
   logic [SW-1:0]     head_ff, head_in, end_ff, end_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              res_ok_ff, res_ok_in;

   logic [SW-1:0] mem_off, mem_val, rd, rd_sz, asz_c, grow_c, addr_c, nb_c, rem_c;

   assign rd      = SW'(mem_rdata);
   assign rd_sz   = rd & SZ_MASK;
   assign mem_idx = mem_off[IW+2:3];
   assign mem_wdata = mem_val[DW-1:0];
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      asz_c  = ((SW'(req_size) + C_ALIGN) >> 3) << 3;
      if (asz_c < C_MIN) begin
         asz_c = C_MIN;
      end
      grow_c = (asize_ff > C_CHUNK) ? asize_ff : C_CHUNK;
      addr_c = SW'(req_free_addr);
      nb_c   = b_ff + rd_sz;
      rem_c  = size_ff - asize_ff;

      state_in    = state_ff;
      ret_in      = ret_ff;
      init_in     = init_ff;
      func_in     = func_ff;
      b_in        = b_ff;
      target_in   = target_ff;
      blk_in      = blk_ff;
      size_in     = size_ff;
      asize_in    = asize_ff;
      before_in   = before_ff;
      x_in        = x_ff;
      n_in        = n_ff;
      p_in        = p_ff;
      t_addr_in   = t_addr_ff;
      t_word_in   = t_word_ff;
      head_in     = head_ff;
      end_in      = end_ff;
      res_addr_in = res_addr_ff;
      res_ok_in   = res_ok_ff;
      mem_we      = 1'b0;
      mem_off     = b_ff;
      mem_val     = '0;
      res         = '0;

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            case (init_ff)
               3'd0: begin
                  mem_off = '0;
                  mem_val = C_WORD | C_ONE;
               end
               3'd1: begin
                  mem_off = C_WORD;
                  mem_val = C_CHUNK - C_TAG;
               end
               3'd2: begin
                  mem_off = C_TAG;
               end
               3'd3: begin
                  mem_off = C_TAG + C_WORD;
               end
               3'd4: begin
                  mem_off = C_CHUNK - C_TAG;
                  mem_val = C_CHUNK - C_TAG;
               end
               default: begin
                  mem_off = C_CHUNK - C_WORD;
                  mem_val = C_ONE;
               end
            endcase
            init_in = init_ff + 3'd1;
            if (init_ff == INIT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               asize_in = asz_c;
               res_addr_in = '0;
               res_ok_in = 1'b0;
               if (req_func == FUNC_ALLOC) begin
                  b_in = head_ff;
                  mem_off = head_ff;
                  if (req_size == '0) begin
                     state_in = ST_RESP;
                  end else if (head_ff == '0) begin
                     state_in = ST_GROW;
                  end else begin
                     state_in = ST_FF_CHK;
                  end
               end else begin
                  b_in = C_WORD;
                  mem_off = C_WORD;
                  target_in = addr_c - C_WORD;
                  if (addr_c < C_TAG || addr_c[2:0] != 3'd0) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_FR_CHK;
                  end
               end
            end
         end
         ST_FF_CHK: begin
            if (rd_sz >= asize_ff) begin
               blk_in = b_ff;
               size_in = rd_sz;
               state_in = ST_PL0;
            end else begin
               mem_off = b_ff + C_WORD;
               state_in = ST_FF_NXT;
            end
         end
         ST_FF_NXT: begin
            b_in = rd;
            mem_off = rd;
            state_in = (rd == '0) ? ST_GROW : ST_FF_CHK;
         end
         ST_GROW: begin
            if (end_ff + grow_c > C_HEAP) begin
               state_in = ST_RESP;
            end else begin
               blk_in = end_ff - C_WORD;
               t_addr_in = end_ff - C_WORD;
               t_word_in = grow_c;
               size_in = grow_c;
               ret_in = ST_GR_EPI;
               state_in = ST_TG0;
            end
         end
         ST_GR_EPI: begin
            mem_we = 1'b1;
            mem_off = blk_ff + size_ff;
            mem_val = C_ONE;
            end_in = end_ff + size_ff;
            state_in = ST_MG_RB;
         end
         ST_FR_CHK: begin
            if (b_ff == target_ff) begin
               if (!rd[0]) begin
                  state_in = ST_RESP;
               end else begin
                  blk_in = b_ff;
                  size_in = rd_sz;
                  t_addr_in = b_ff;
                  t_word_in = rd_sz;
                  ret_in = ST_MG_RB;
                  state_in = ST_TG0;
               end
            end else if (rd_sz < C_WORD || nb_c >= end_ff - C_WORD) begin
               state_in = ST_RESP;
            end else begin
               b_in = nb_c;
               mem_off = nb_c;
            end
         end
         ST_MG_RB: begin
            mem_off = blk_ff - C_WORD;
            state_in = ST_MG_RA;
         end
         ST_MG_RA: begin
            before_in = rd;
            mem_off = blk_ff + size_ff;
            state_in = ST_MG_AF;
         end
         ST_MG_AF: begin
            state_in = ST_MG_BF;
            if (!rd[0]) begin
               x_in = blk_ff + size_ff;
               size_in = size_ff + rd_sz;
               ret_in = ST_MG_BF;
               state_in = ST_LR0;
            end
         end
         ST_MG_BF: begin
            state_in = ST_MG_TG;
            if (!before_ff[0]) begin
               x_in = blk_ff - (before_ff & SZ_MASK);
               blk_in = blk_ff - (before_ff & SZ_MASK);
               size_in = size_ff + (before_ff & SZ_MASK);
               ret_in = ST_MG_TG;
               state_in = ST_LR0;
            end
         end
         ST_MG_TG: begin
            t_addr_in = blk_ff;
            t_word_in = size_ff;
            ret_in = ST_MG_PS;
            state_in = ST_TG0;
         end
         ST_MG_PS: begin
            x_in = blk_ff;
            state_in = ST_PU0;
            if (func_ff == FUNC_ALLOC) begin
               ret_in = ST_PL0;
            end else begin
               ret_in = ST_RESP;
               res_ok_in = 1'b1;
            end
         end
         ST_PL0: begin
            x_in = blk_ff;
            ret_in = ST_PL1;
            state_in = ST_LR0;
         end
         ST_PL1: begin
            t_addr_in = blk_ff;
            state_in = ST_TG0;
            if (rem_c >= C_MIN) begin
               t_word_in = asize_ff | C_ONE;
               ret_in = ST_PL2;
            end else begin
               t_word_in = size_ff | C_ONE;
               ret_in = ST_RESP;
               res_addr_in = ADDR_W'(blk_ff + C_WORD);
               res_ok_in = 1'b1;
            end
         end
         ST_PL2: begin
            t_addr_in = blk_ff + asize_ff;
            t_word_in = rem_c;
            ret_in = ST_PL3;
            state_in = ST_TG0;
         end
         ST_PL3: begin
            x_in = blk_ff + asize_ff;
            ret_in = ST_RESP;
            res_addr_in = ADDR_W'(blk_ff + C_WORD);
            res_ok_in = 1'b1;
            state_in = ST_PU0;
         end
         ST_LR0: begin
            mem_off = x_ff + C_WORD;
            state_in = ST_LR1;
         end
         ST_LR1: begin
            n_in = rd;
            mem_off = x_ff + C_TAG;
            state_in = ST_LR2;
         end
         ST_LR2: begin
            p_in = rd;
            if (rd != '0) begin
               mem_we = 1'b1;
               mem_off = rd + C_WORD;
               mem_val = n_ff;
            end else begin
               head_in = n_ff;
            end
            state_in = ST_LR3;
         end
         ST_LR3: begin
            mem_off = n_ff + C_TAG;
            mem_val = p_ff;
            mem_we = (n_ff != '0);
            state_in = ret_ff;
         end
         ST_TG0: begin
            mem_we = 1'b1;
            mem_off = t_addr_ff;
            mem_val = t_word_ff;
            state_in = ST_TG1;
         end
         ST_TG1: begin
            mem_we = 1'b1;
            mem_off = t_addr_ff + (t_word_ff & SZ_MASK) - C_WORD;
            mem_val = t_word_ff;
            state_in = ret_ff;
         end
         ST_PU0: begin
            mem_we = 1'b1;
            mem_off = x_ff + C_WORD;
            mem_val = head_ff;
            state_in = ST_PU1;
         end
         ST_PU1: begin
            mem_we = 1'b1;
            mem_off = x_ff + C_TAG;
            state_in = ST_PU2;
         end
         ST_PU2: begin
            mem_we = (head_ff != '0);
            mem_off = head_ff + C_TAG;
            mem_val = x_ff;
            head_in = x_ff;
            state_in = ret_ff;
         end
         ST_RESP: begin
            if (!out_busy) begin
               res.valid = 1'b1;
               res.addr = res_addr_ff;
               res.ok = res_ok_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         init_ff  <= '0;
         ret_ff   <= ST_IDLE;
         head_ff  <= C_WORD;
         end_ff   <= C_CHUNK;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         ret_ff   <= ret_in;
         head_ff  <= head_in;
         end_ff   <= end_in;
      end
      func_ff     <= func_in;
      b_ff        <= b_in;
      target_ff   <= target_in;
      blk_ff      <= blk_in;
      size_ff     <= size_in;
      asize_ff    <= asize_in;
      before_ff   <= before_in;
      x_ff        <= x_in;
      n_ff        <= n_in;
      p_ff        <= p_in;
      t_addr_ff   <= t_addr_in;
      t_word_ff   <= t_word_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
   end

endmodule

// File: src/explicit_free_list_heap_allocator_top.sv
// Heap allocator with an explicit free list, first-fit search and boundary-tag
// coalescing, kept in a single-port heap memory of 8-byte words accessed once
// per cycle. After reset the block writes the initial heap layout with req_stall
// high. An allocate walks the free list from its head until a block fits,
// growing the heap when none does, and splits that block when the remainder is
// at least MIN_BLOCK bytes; a free walks the heap blocks from the bottom of the
// heap to validate the address and then coalesces the block with its free
// neighbours. One word is in flight at a time; a finished result waits in the
// output register while the next word is accepted.
module explicit_free_list_heap_allocator_top #(
   parameter int HEAP_BYTES  = efla_pkg::HEAP_BYTES_DEF,
   parameter int CHUNK_BYTES = efla_pkg::CHUNK_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [efla_pkg::REQ_W-1:0]  req_size,
   input  logic [efla_pkg::ADDR_W-1:0] req_free_addr,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [efla_pkg::ADDR_W-1:0] rsp_payload_addr,
   output logic                        rsp_ok
);
   import efla_pkg::*;

   localparam int DW = $clog2(HEAP_BYTES) + 1;
   localparam int IW = $clog2(HEAP_BYTES / 8);

   logic              mem_we;
   logic [IW-1:0]     mem_idx;
   logic [DW-1:0]     mem_wdata, mem_rdata;
   logic              out_busy;
   res_type           res;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_ok_ff, rsp_ok_in;

   efla_ram #(
      .WIDTH(DW),
      .DEPTH(HEAP_BYTES / 8)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_idx),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   efla_ctrl #(
      .HEAP_BYTES (HEAP_BYTES),
      .CHUNK_BYTES(CHUNK_BYTES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_size     (req_size),
      .req_free_addr(req_free_addr),
      .mem_we       (mem_we),
      .mem_idx      (mem_idx),
      .mem_wdata    (mem_wdata),
      .mem_rdata    (mem_rdata),
      .out_busy     (out_busy),
      .res          (res)
   );

   assign out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res.addr;
         rsp_ok_in    = res.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff <= rsp_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_addr = rsp_addr_ff;
   assign rsp_ok           = rsp_ok_ff;

endmodule

// File: src/efla_checker.sv
module efla_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_func,
   input logic [efla_pkg::REQ_W-1:0]  req_size,
   input logic [efla_pkg::ADDR_W-1:0] req_free_addr,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [efla_pkg::ADDR_W-1:0] rsp_payload_addr,
   input logic                        rsp_ok
);

   // heap layout is written before any word is taken
   a_init_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during heap setup");

   // one word at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_payload_addr == '0)
      else $error("failed word carries an address");

   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_payload_addr[2:0] == 3'd0)
      else $error("misaligned payload address");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_addr) && $stable(rsp_ok))
      else $error("stalled result changed");

endmodule

bind explicit_free_list_heap_allocator_top efla_checker u_efla_checker (.*);
